// ----- hdl/touch_button_press_hold_release_assert.svh -----
// assertion macros for the touch button tracker
`ifndef TOUCH_BUTTON_PRESS_HOLD_RELEASE_ASSERT_SVH
`define TOUCH_BUTTON_PRESS_HOLD_RELEASE_ASSERT_SVH

// same-cycle implication
`define TBPHR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbphr assertion failed");

// next-cycle implication
`define TBPHR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbphr assertion failed");

`endif

// ----- hdl/tbphr_pkg.sv -----
package tbphr_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int LANES       = 6;
    localparam int NUM_LANES   = (NUM_BUTTONS < LANES) ? NUM_BUTTONS : LANES;
    localparam int MASK_W      = 6;
    localparam int DELTA_W     = 8;
    localparam int THR_W       = 8;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = 3;
    localparam logic [THR_W-1:0] THR_RESET = 8'd64;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_HELD    = 2'd2
    } t_phase;

    typedef struct packed {
        logic                      new_event;
        logic [MASK_W-1:0]         touched_mask;
        logic signed [DELTA_W-1:0] delta_0;
        logic signed [DELTA_W-1:0] delta_1;
        logic signed [DELTA_W-1:0] delta_2;
        logic signed [DELTA_W-1:0] delta_3;
        logic signed [DELTA_W-1:0] delta_4;
        logic signed [DELTA_W-1:0] delta_5;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] press_mask;
        logic [MASK_W-1:0] hold_mask;
        logic [MASK_W-1:0] release_mask;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic new_event;
        logic armed;
    } t_lane_ctl;

    typedef struct packed {
        logic press;
        logic hold;
        logic rel;
    } t_lane_evt;

endpackage

// ----- hdl/touch_button_press_hold_release.sv -----
// channel   direction  handshake                    payload
// poll      in         i_in_valid / o_in_ready      i_in_data (t_in_item)
// events    out        o_out_valid / i_out_ready    o_out_data (t_out_item)
// config    in         psel penable pwrite pready   paddr, pwdata, prdata
//
// one poll per cycle while the output is free or drains; its event masks are
// registered at the transfer, set by the single per-button phase update in each lane
// synchronous active-low reset: all buttons idle, release check disarmed,
// thresholds 64
// a stalled output only blocks input when the output register is still full
`include "touch_button_press_hold_release_assert.svh"

module touch_button_press_hold_release
    import tbphr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [THR_W-1:0]          r_threshold [LANES];
    logic                      r_armed;
    logic                      w_accept;
    logic                      w_cfg_wr;
    logic [REG_IDX_W-1:0]      w_reg_idx;
    logic                      w_reg_ok;
    logic signed [DELTA_W-1:0] w_delta [LANES];
    t_lane_evt                 w_evt [LANES];
    t_lane_ctl                 w_ctl;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg_idx  = paddr[APB_AW-1:2];
    assign w_reg_ok   = (w_reg_idx < REG_IDX_W'(LANES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_threshold[i] <= THR_RESET;
            end
        end else if (w_cfg_wr && w_reg_ok) begin
            r_threshold[w_reg_idx] <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_ok) begin
            prdata = {{(APB_DW-THR_W){1'b0}}, r_threshold[w_reg_idx]};
        end
    end

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (w_accept) begin
            if (i_in_data.new_event) begin
                r_armed <= 1'b1;
            end else begin
                r_armed <= 1'b0;
            end
        end
    end

    assign w_ctl.accept    = w_accept;
    assign w_ctl.new_event = i_in_data.new_event;
    assign w_ctl.armed     = r_armed;

    assign w_delta[0] = i_in_data.delta_0;
    assign w_delta[1] = i_in_data.delta_1;
    assign w_delta[2] = i_in_data.delta_2;
    assign w_delta[3] = i_in_data.delta_3;
    assign w_delta[4] = i_in_data.delta_4;
    assign w_delta[5] = i_in_data.delta_5;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < NUM_LANES) begin : g_on
            tbphr_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_touched   (i_in_data.touched_mask[g]),
                .i_delta     (w_delta[g]),
                .i_threshold (r_threshold[g]),
                .o_evt       (w_evt[g])
            );
        end else begin : g_off
            assign w_evt[g] = '0;
        end
    end

    tbphr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_evt       (w_evt),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `TBPHR_ASSERT_NOW(a_masks_disjoint, o_out_valid,
        ((o_out_data.press_mask & o_out_data.hold_mask) |
         (o_out_data.press_mask & o_out_data.release_mask) |
         (o_out_data.hold_mask & o_out_data.release_mask)) == '0)
    `TBPHR_ASSERT_NEXT(a_idle_poll_quiet, w_accept && !i_in_data.new_event && !r_armed,
        (o_out_data.press_mask | o_out_data.hold_mask | o_out_data.release_mask) == '0)
    `TBPHR_ASSERT_NEXT(a_event_arms, w_accept && i_in_data.new_event,
        r_armed && (o_out_data.release_mask == '0))

endmodule

// ----- hdl/tbphr_lane.sv -----
module tbphr_lane
    import tbphr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_ctl                 i_ctl,
    input  logic                      i_touched,
    input  logic signed [DELTA_W-1:0] i_delta,
    input  logic [THR_W-1:0]          i_threshold,
    output t_lane_evt                 o_evt
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic signed [DELTA_W:0] w_delta_x;
    logic signed [THR_W:0]   w_thr_x;
    logic                w_hit;

    assign w_delta_x = {i_delta[DELTA_W-1], i_delta};
    assign w_thr_x   = {1'b0, i_threshold};
    assign w_hit     = i_touched && (w_delta_x >= w_thr_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        o_evt   = '0;
        if (i_ctl.accept) begin
            if (i_ctl.new_event) begin
                if (w_hit) begin
                    case (r_phase)
                        PH_PRESSED: begin
                            n_phase   = PH_HELD;
                            o_evt.hold = 1'b1;
                        end
                        PH_HELD: begin
                            n_phase = PH_HELD;
                        end
                        default: begin
                            n_phase    = PH_PRESSED;
                            o_evt.press = 1'b1;
                        end
                    endcase
                end
            end else if (i_ctl.armed && !i_touched) begin
                case (r_phase)
                    PH_PRESSED, PH_HELD: begin
                        n_phase   = PH_IDLE;
                        o_evt.rel = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

endmodule

// ----- hdl/tbphr_merge.sv -----
module tbphr_merge
    import tbphr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_lane_evt i_evt [LANES],
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;

    always_comb begin
        n_data = '0;
        for (int i = 0; i < LANES; i++) begin
            n_data.press_mask[i]   = i_evt[i].press;
            n_data.hold_mask[i]    = i_evt[i].hold;
            n_data.release_mask[i] = i_evt[i].rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ----- test/touch_button_press_hold_release_tb.sv -----
`timescale 1ns / 1ps

module touch_button_press_hold_release_tb;
    import tbphr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int REG_STRIDE   = 4;
    localparam int RANDOM_POLLS = 800;

    typedef enum logic {ROW_POLL, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_in_item         poll;
        bit               typed;
        t_out_item        events;
        int               reg_idx;
        logic [THR_W-1:0] reg_val;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    touch_button_press_hold_release dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // tracker copy: thresholds, per-button phase, release check
    logic [THR_W-1:0] thr_model [LANES];
    t_phase           btn_phase [LANES];
    logic             release_armed;

    t_out_item expected_events [$];
    t_row      directed_rows [$];
    t_out_item got_events;

    int  send_gap_pct;
    int  recv_stall_pct;
    bit  poll_up;
    int  mismatches;
    int  n_polls;
    int  n_directed;
    int  n_results;
    int  n_press;
    int  n_hold;
    int  n_release;
    int  cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_events.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic t_out_item predict_events(t_in_item p);
        logic signed [DELTA_W-1:0] dl [LANES];
        t_out_item ev;
        int dv;
        int tv;
        dl[0] = p.delta_0;
        dl[1] = p.delta_1;
        dl[2] = p.delta_2;
        dl[3] = p.delta_3;
        dl[4] = p.delta_4;
        dl[5] = p.delta_5;
        ev = '0;
        if (p.new_event) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                dv = dl[i];
                tv = thr_model[i];
                if (p.touched_mask[i] && dv >= tv) begin
                    if (btn_phase[i] == PH_PRESSED) begin
                        btn_phase[i] = PH_HELD;
                        ev.hold_mask[i] = 1'b1;
                    end else if (btn_phase[i] != PH_HELD) begin
                        btn_phase[i] = PH_PRESSED;
                        ev.press_mask[i] = 1'b1;
                    end
                end
            end
            release_armed = 1'b1;
        end else if (release_armed) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                if ((btn_phase[i] == PH_PRESSED || btn_phase[i] == PH_HELD)
                        && !p.touched_mask[i]) begin
                    ev.release_mask[i] = 1'b1;
                    btn_phase[i] = PH_IDLE;
                end
            end
            release_armed = 1'b0;
        end
        return ev;
    endfunction

    // about half of the deltas close to the threshold so buttons step through their phases
    function automatic t_in_item rand_poll();
        t_in_item p;
        logic [DELTA_W-1:0] d [LANES];
        logic [63:0] raw;
        int v;
        int mode;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom(), $urandom()};
            p = raw[$bits(t_in_item)-1:0];
            return p;
        end
        for (int i = 0; i < LANES; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
                d[i] = DELTA_W'($urandom_range(0, 255));
            end else if (mode < 8) begin
                v = int'(thr_model[i]) + int'($urandom_range(0, 6)) - 3;
                if (v > 127)
                    v = 127;
                if (v < -128)
                    v = -128;
                d[i] = v[DELTA_W-1:0];
            end else begin
                case ($urandom_range(0, 3))
                    0: d[i] = 8'h7F;
                    1: d[i] = 8'h80;
                    2: d[i] = 8'h00;
                    default: d[i] = 8'hFF;
                endcase
            end
        end
        p.new_event = ($urandom_range(0, 99) < 55);
        for (int i = 0; i < MASK_W; i++)
            p.touched_mask[i] = ($urandom_range(0, 99) < 70);
        p.delta_0 = d[0];
        p.delta_1 = d[1];
        p.delta_2 = d[2];
        p.delta_3 = d[3];
        p.delta_4 = d[4];
        p.delta_5 = d[5];
        return p;
    endfunction

    function automatic void add_poll(logic ne, logic [MASK_W-1:0] tm,
                                     logic [6*DELTA_W-1:0] dl, bit typed,
                                     logic [3*MASK_W-1:0] ev);
        t_row r;
        r.kind = ROW_POLL;
        r.poll = {ne, tm, dl};
        r.typed = typed;
        r.events = ev;
        r.reg_idx = 0;
        r.reg_val = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(int idx, logic [THR_W-1:0] val);
        t_row r;
        r.kind = ROW_CFG;
        r.poll = '0;
        r.typed = 1'b0;
        r.events = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        directed_rows.push_back(r);
    endfunction

    task automatic lower_poll();
        if (poll_up) begin
            i_in_valid <= 1'b0;
            poll_up = 1'b0;
        end
    endtask

    task automatic send_poll(input t_in_item it, input bit typed, input t_out_item ev);
        t_out_item pred;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            lower_poll();
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        poll_up = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_events(it);
        expected_events.push_back(typed ? ev : pred);
        n_polls++;
        @(negedge i_clk);
    endtask

    task automatic drain_polls();
        lower_poll();
        while (expected_events.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input int idx, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_AW'(idx * REG_STRIDE);
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr && idx < LANES)
            thr_model[idx] = wdata[THR_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_threshold(input int idx, input logic [THR_W-1:0] val);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b1, idx, APB_DW'(val), rd);
        if (idx < LANES) begin
            apb_xfer(1'b0, idx, '0, rd);
            if (rd !== APB_DW'(thr_model[idx]))
                flag_mismatch($sformatf("threshold_%0d readback: expected %0h, got %0h",
                                        idx, thr_model[idx], rd));
        end
    endtask

    task automatic run_phase(input int gap, input int stall, input int count,
                             input logic [THR_W-1:0] thr_set [LANES]);
        drain_polls();
        send_gap_pct = gap;
        recv_stall_pct = stall;
        for (int i = 0; i < LANES; i++)
            set_threshold(i, thr_set[i]);
        repeat (count)
            send_poll(rand_poll(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                flag_mismatch($sformatf("event transfer with nothing expected: %h", o_out_data));
            end else begin
                got_events = expected_events.pop_front();
                if (o_out_data.press_mask !== got_events.press_mask)
                    flag_mismatch($sformatf("press_mask: expected %b, got %b",
                                            got_events.press_mask, o_out_data.press_mask));
                if (o_out_data.hold_mask !== got_events.hold_mask)
                    flag_mismatch($sformatf("hold_mask: expected %b, got %b",
                                            got_events.hold_mask, o_out_data.hold_mask));
                if (o_out_data.release_mask !== got_events.release_mask)
                    flag_mismatch($sformatf("release_mask: expected %b, got %b",
                                            got_events.release_mask, o_out_data.release_mask));
                n_results++;
                n_press += $countones(o_out_data.press_mask);
                n_hold += $countones(o_out_data.hold_mask);
                n_release += $countones(o_out_data.release_mask);
            end
        end
    end

    initial begin
        logic [THR_W-1:0] thr_set [LANES];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        poll_up = 1'b0;
        mismatches = 0;
        n_polls = 0;
        n_results = 0;
        n_press = 0;
        n_hold = 0;
        n_release = 0;
        send_gap_pct = 10;
        recv_stall_pct = 63;
        for (int i = 0; i < LANES; i++) begin
            thr_model[i] = THR_RESET;
            btn_phase[i] = PH_IDLE;
        end
        release_armed = 1'b0;

        // reset thresholds of 64
        add_poll(1'b0, 6'h00, {6{8'h00}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b1, 6'h3F, {6{8'h7F}}, 1'b1, {6'h3F, 6'h00, 6'h00});
        add_poll(1'b1, 6'h3F, {6{8'h40}}, 1'b1, {6'h00, 6'h3F, 6'h00});
        add_poll(1'b1, 6'h3F, {6{8'h7F}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b0, 6'h00, {6{8'h80}}, 1'b1, {6'h00, 6'h00, 6'h3F});
        add_poll(1'b0, 6'h00, {6{8'h00}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b1, 6'h3F, {6{8'h3F}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b0, 6'h00, {6{8'h00}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b1, 6'h00, {6{8'h7F}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b1, 6'h15, {6{8'h7F}}, 1'b1, {6'h15, 6'h00, 6'h00});
        add_poll(1'b1, 6'h2A, {6{8'h80}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b0, 6'h01, {6{8'hFF}}, 1'b1, {6'h00, 6'h00, 6'h14});
        add_poll(1'b1, 6'h3F, {6{8'h7F}}, 1'b1, {6'h3E, 6'h01, 6'h00});
        add_poll(1'b0, 6'h00, {6{8'h00}}, 1'b1, {6'h00, 6'h00, 6'h3F});
        // threshold extremes, writes past the last register are dropped
        add_cfg(0, 8'd0);
        add_cfg(1, 8'd255);
        add_cfg(2, 8'd128);
        add_cfg(3, 8'd127);
        add_cfg(4, 8'd0);
        add_cfg(5, 8'd1);
        add_cfg(6, 8'd0);
        add_cfg(7, 8'd0);
        add_poll(1'b1, 6'h3F, {8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h00, 8'h00}, 1'b1,
                 {6'h18, 6'h00, 6'h00});
        add_poll(1'b1, 6'h3F, {8'h00, 8'h80, 8'h80, 8'h7F, 8'h80, 8'h01}, 1'b0, '0);
        add_poll(1'b0, 6'h08, {6{8'h00}}, 1'b0, '0);
        add_poll(1'b0, 6'h00, {6{8'h00}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b1, 6'h3F, {6{8'h80}}, 1'b1, {6'h00, 6'h00, 6'h00});
        add_poll(1'b0, 6'h3F, {6{8'h00}}, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                drain_polls();
                set_threshold(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                send_poll(directed_rows[k].poll, directed_rows[k].typed,
                          directed_rows[k].events);
            end
        end
        n_directed = n_polls;

        for (int i = 0; i < LANES; i++)
            thr_set[i] = THR_W'($urandom_range(0, 127));
        run_phase(10, 63, RANDOM_POLLS / 3, thr_set);

        thr_set = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd64};
        thr_set[5] = THR_W'($urandom_range(0, 255));
        run_phase(63, 10, RANDOM_POLLS / 3, thr_set);

        for (int i = 0; i < LANES; i++)
            thr_set[i] = THR_W'($urandom_range(0, 255));
        run_phase(0, 0, RANDOM_POLLS - 2 * (RANDOM_POLLS / 3), thr_set);

        drain_polls();
        repeat (4) @(negedge i_clk);

        $display("%0d polls (%0d directed) over 5 threshold settings, %0d event results",
                 n_polls, n_directed, n_results);
        $display("events seen: %0d presses, %0d holds, %0d releases; %0d mismatches",
                 n_press, n_hold, n_release, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
